@@ sv/flag_map_zero_fill_decoder_unit_assert.svh @@
// Assertion macros shared by the zero-fill decoder checker.
`ifndef FLAG_MAP_ZERO_FILL_DECODER_UNIT_ASSERT_SVH
`define FLAG_MAP_ZERO_FILL_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define FMZFD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fmzfd check failed");

// Next-cycle implication, disabled while reset is active.
`define FMZFD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fmzfd check failed");

`endif

@@ sv/fmzfd_pkg.sv @@
// Package: constants, state and control types of the zero-fill decoder.
package fmzfd_pkg;

	localparam logic [4:0] GROUPS        = 5'd24;
	localparam logic [8:0] IN_LIMIT      = 9'd198;
	localparam logic [8:0] OUT_LIMIT     = 9'd192;
	localparam logic [3:0] FLAGS_PER_MAP = 4'd8;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_EXPAND
	} fmzfd_state_t;

	typedef struct packed {
		logic accept;
		logic emit_zero;
		logic set_want;
	} fmzfd_cmd_t;

	typedef struct packed {
		logic finished;
		logic flags_left_nz;
		logic flag_bit0;
		logic out_free;
	} fmzfd_status_t;

endpackage

@@ sv/flag_map_zero_fill_decoder_unit.sv @@
// Top level of the zero-fill bitmap decoder.
// Input channel (in_valid/in_ready): one stream byte per transfer in data_byte;
// first = 1 clears all counters and takes the byte as the map byte of a new image.
// Output channel (out_valid/out_ready): one decoded byte per transfer with its
// position out_index; last marks the final byte of the image.
// Each map byte yields a zero for every set flag, least significant flag first,
// until a clear flag asks for the next byte as a literal.
// A literal is registered at its transfer and shows on the output in the cycle
// after it; zeros follow one per cycle while the receiver is ready. A new input
// is taken only once the controller's expand loop, which emits the zeros through
// the single output register, has returned to idle.
// After the image ends, bytes without first are taken and dropped.
// Reset clears all counters; decoding may start at once without a first byte.
// While the receiver stalls, the output register holds its byte and the
// expand loop waits; no input is taken until that byte is gone.
module flag_map_zero_fill_decoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       first,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [7:0] out_index,
	output logic       last
);

	fmzfd_pkg::fmzfd_cmd_t    cmd;
	fmzfd_pkg::fmzfd_status_t status;

	fmzfd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.status  (status),
		.cmd     (cmd)
	);

	fmzfd_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.data_byte(data_byte),
		.first    (first),
		.out_ready(out_ready),
		.status   (status),
		.out_valid(out_valid),
		.out_byte (out_byte),
		.out_index(out_index),
		.last     (last)
	);

endmodule

@@ sv/fmzfd_dpath.sv @@
// Datapath: decoder state registers, emit logic and output register.
module fmzfd_dpath (
	input  logic                    clk,
	input  logic                    arst_n,
	input  fmzfd_pkg::fmzfd_cmd_t   cmd,
	input  logic [7:0]              data_byte,
	input  logic                    first,
	input  logic                    out_ready,
	output fmzfd_pkg::fmzfd_status_t status,
	output logic                    out_valid,
	output logic [7:0]              out_byte,
	output logic [7:0]              out_index,
	output logic                    last
);

	logic       want_q;
	logic [7:0] flag_bits_q;
	logic [3:0] flags_left_q;
	logic [4:0] group_q;
	logic [8:0] in_count_q;
	logic [8:0] out_count_q;
	logic       finished_q;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic [7:0] out_index_q;
	logic       last_q;

	logic       base_want, base_fin;
	logic [7:0] base_fb;
	logic [3:0] base_fl;
	logic [4:0] base_gc;
	logic [8:0] base_ic, base_oc, in_inc;
	logic       take, lit_emit, do_emit;

	logic [7:0] src_fb;
	logic [3:0] src_fl;
	logic [4:0] src_gc;
	logic [8:0] src_ic, src_oc;

	logic [7:0] e_fb, e_value;
	logic [3:0] e_fl;
	logic [4:0] e_gc;
	logic [8:0] e_oc;
	logic       e_grp_done, e_fin;

	// A first byte sees the cleared state.
	always_comb begin
		base_want = first ? 1'b0 : want_q;
		base_fb   = first ? 8'd0 : flag_bits_q;
		base_fl   = first ? 4'd0 : flags_left_q;
		base_gc   = first ? 5'd0 : group_q;
		base_ic   = first ? 9'd0 : in_count_q;
		base_oc   = first ? 9'd0 : out_count_q;
		base_fin  = first ? 1'b0 : finished_q;
		in_inc    = (base_ic == 9'h1FF) ? base_ic : base_ic + 9'd1;
		take      = cmd.accept && !base_fin;
		lit_emit  = take && base_want;
		do_emit   = lit_emit || cmd.emit_zero;
	end

	always_comb begin
		if (cmd.accept) begin
			src_fb = base_fb;
			src_fl = base_fl;
			src_gc = base_gc;
			src_ic = in_inc;
			src_oc = base_oc;
		end else begin
			src_fb = flag_bits_q;
			src_fl = flags_left_q;
			src_gc = group_q;
			src_ic = in_count_q;
			src_oc = out_count_q;
		end
		e_value    = cmd.accept ? data_byte : 8'd0;
		e_oc       = src_oc + 9'd1;
		e_fb       = src_fb >> 1;
		e_fl       = (src_fl != 4'd0) ? src_fl - 4'd1 : src_fl;
		e_grp_done = (e_fl == 4'd0);
		e_gc       = e_grp_done ? src_gc + 5'd1 : src_gc;
		e_fin      = (e_grp_done && (e_gc >= fmzfd_pkg::GROUPS))
			|| (src_ic > fmzfd_pkg::IN_LIMIT) || (e_oc > fmzfd_pkg::OUT_LIMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			want_q       <= 1'b0;
			flag_bits_q  <= 8'd0;
			flags_left_q <= 4'd0;
			group_q      <= 5'd0;
			in_count_q   <= 9'd0;
			out_count_q  <= 9'd0;
			finished_q   <= 1'b0;
		end else if (take) begin
			in_count_q <= in_inc;
			want_q     <= 1'b0;
			if (!base_want) begin
				// map byte: load a fresh group
				flag_bits_q  <= data_byte;
				flags_left_q <= fmzfd_pkg::FLAGS_PER_MAP;
				group_q      <= base_gc;
				out_count_q  <= base_oc;
				finished_q   <= 1'b0;
			end else begin
				flag_bits_q  <= e_fb;
				flags_left_q <= e_fl;
				group_q      <= e_gc;
				out_count_q  <= e_oc;
				finished_q   <= e_fin;
			end
		end else if (cmd.emit_zero) begin
			flag_bits_q  <= e_fb;
			flags_left_q <= e_fl;
			group_q      <= e_gc;
			out_count_q  <= e_oc;
			finished_q   <= e_fin;
		end else if (cmd.set_want) begin
			want_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_emit) begin
			out_byte_q  <= e_value;
			out_index_q <= src_oc[7:0];
			last_q      <= e_fin;
		end
	end

	always_comb begin
		status.finished      = finished_q;
		status.flags_left_nz = (flags_left_q != 4'd0);
		status.flag_bit0     = flag_bits_q[0];
		status.out_free      = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_index = out_index_q;
	assign last      = last_q;

endmodule

@@ sv/fmzfd_ctrl.sv @@
// Controller: takes stream bytes and steps through the zero flags of a group.
module fmzfd_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  fmzfd_pkg::fmzfd_status_t status,
	output fmzfd_pkg::fmzfd_cmd_t    cmd
);

	fmzfd_pkg::fmzfd_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fmzfd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			fmzfd_pkg::ST_IDLE: begin
				in_ready = status.out_free;
				if (in_valid && status.out_free) begin
					cmd.accept = 1'b1;
					state_d    = fmzfd_pkg::ST_EXPAND;
				end
			end
			fmzfd_pkg::ST_EXPAND: begin
				if (status.finished || !status.flags_left_nz) begin
					state_d = fmzfd_pkg::ST_IDLE;
				end else if (status.flag_bit0) begin
					// hold while the output register is full
					cmd.emit_zero = status.out_free;
				end else begin
					cmd.set_want = 1'b1;
					state_d      = fmzfd_pkg::ST_IDLE;
				end
			end
			default: state_d = fmzfd_pkg::ST_IDLE;
		endcase
	end

endmodule

@@ sv/fmzfd_checker.sv @@
// Port-level checker for the zero-fill decoder, bound to the top level.
`include "flag_map_zero_fill_decoder_unit_assert.svh"

module fmzfd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic [7:0] out_index,
	input logic       last
);

	`FMZFD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
	`FMZFD_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_byte) && $stable(out_index) && $stable(last))
	`FMZFD_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready)
	`FMZFD_ASSERT_NXT(a_quiet_after_last, out_valid && out_ready && last, !out_valid)

endmodule

bind flag_map_zero_fill_decoder_unit fmzfd_checker u_fmzfd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_byte (out_byte),
	.out_index(out_index),
	.last     (last)
);
